>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants and types for the windowed stillness detector: window
// depth, field widths, register indexes and the vector and sum types.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Window depth in samples
    localparam int WINDOW = 10;
    // Components per sample: linear x/y/z then angular x/y/z
    localparam int NCOMP  = 6;
    localparam int NVEC   = 3;
    localparam int DATA_W = 32;
    localparam int THR_W  = 31;
    // A sum of WINDOW samples needs clog2(WINDOW) extra bits
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int POS_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int SQ_W   = 2 * THR_W;
    // Three squares of SQ_W bits
    localparam int ACC_W  = SQ_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_THR = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 31'd105;

    typedef logic [DATA_W-1:0] t_comp;
    typedef t_comp [NCOMP-1:0] t_vec;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef t_sum  [NCOMP-1:0] t_sums;

    // Window state after the latest update
    typedef struct packed {
        logic  full;
        t_sums sums;
    } t_win_state;

endpackage

>>> rtl/wsd_window.sv
// ----------------------------------------------------------------------------
// wsd_window
// Sample window: a delay line of the last WINDOW samples, the running sum of
// each component and the ring position with its wrapped flag.
// ----------------------------------------------------------------------------
module wsd_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wsd_pkg::t_vec         i_sample,
    output wsd_pkg::t_win_state   o_state
);
    import wsd_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    t_vec             r_line [WINDOW];
    t_sums            r_sum;
    t_sums            n_sum;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_full;
    t_vec             evicted;

    // Entries older than the first wrap were never written: they read as zero
    assign evicted = r_full ? r_line[WINDOW-1] : '0;

    // Running sums: add the new sample, drop the one leaving the window
    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            n_sum[k] = r_sum[k]
                     + {{(SUM_W-DATA_W){i_sample[k][DATA_W-1]}}, i_sample[k]}
                     - {{(SUM_W-DATA_W){evicted[k][DATA_W-1]}}, evicted[k]};
        end
    end

    assign n_pos = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);

    // Control state and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_push) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (r_pos == POS_LAST) begin
                r_full <= 1'b1;
            end
        end
    end

    // Delay line, payload only
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_line[0] <= i_sample;
            for (int i = 1; i < WINDOW; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_state.full = r_full;
    assign o_state.sums = r_sum;

    // Position stays inside the window
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("ring position out of range");

    // Window becomes full exactly when the position wraps to zero
    a_full_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && r_pos == POS_LAST |=> r_full && r_pos == '0)
        else $error("wrap did not set full");

    // Full only rises together with a wrap
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> r_pos == '0)
        else $error("full rose away from wrap");

    // Once full, stays full until reset
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("full flag dropped");

endmodule

>>> rtl/windowed_stillness_detector.sv
// ----------------------------------------------------------------------------
// windowed_stillness_detector
// Moving-sum stillness detector: reports at rest when the summed linear and
// angular velocity over the last WINDOW samples are both under threshold and the window is full.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes four register stages before its result
//   is valid (input, window update, squares, compare).
// Throughput: one item per cycle; the stages advance independently, so a
//   held result only stalls input once the pipeline has no bubbles left.
// Reset: clears sums, ring position, full flag and pipeline valids; both
//   thresholds return to 105. No clearing pass, items accepted at once.
module windowed_stillness_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_lin_x,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_lin_y,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_lin_z,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_ang_x,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_ang_y,
    input  logic signed [wsd_pkg::DATA_W-1:0] i_ang_z,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_at_rest,
    output logic                              o_window_full,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wsd_pkg::THR_W-1:0]         i_cfg_data
);
    import wsd_pkg::*;

    logic [THR_W-1:0] r_lin_thr;
    logic [THR_W-1:0] r_ang_thr;

    // Pipeline valids and stage enables
    logic r_v1, r_v2, r_v3, r_vo;
    logic rdy1, rdy2, rdy3, rdy4;

    t_vec       r_in;
    t_win_state win;

    logic [SQ_W-1:0] r_sq [NCOMP];
    logic [SQ_W-1:0] n_sq [NCOMP];
    logic [SQ_W-1:0] r_lin_tsq;
    logic [SQ_W-1:0] r_ang_tsq;
    logic [NCOMP-1:0] n_big;
    logic            r_lin_big;
    logic            r_ang_big;
    logic            r_full3;

    logic [ACC_W-1:0] lin_acc;
    logic [ACC_W-1:0] ang_acc;
    logic             n_at_rest;
    logic             r_at_rest;
    logic             r_full_o;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_thr <= THR_RESET;
            r_ang_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIN_THR: r_lin_thr <= i_cfg_data;
                CFG_ANG_THR: r_ang_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a new item when empty or when its item moves on
    assign rdy4 = !r_vo || i_out_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_vo <= r_v3;
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_in[0] <= i_lin_x;
            r_in[1] <= i_lin_y;
            r_in[2] <= i_lin_z;
            r_in[3] <= i_ang_x;
            r_in[4] <= i_ang_y;
            r_in[5] <= i_ang_z;
        end
    end

    // Stage 2: window update, its state holds the stage result
    wsd_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_v1 && rdy2),
        .i_sample (r_in),
        .o_state  (win)
    );

    // Stage 3: magnitudes and squares. Any magnitude of 2^THR_W or more
    // already exceeds every threshold squared, so only the low bits are squared.
    always_comb begin
        t_sum mag;
        for (int k = 0; k < NCOMP; k++) begin
            mag      = win.sums[k][SUM_W-1] ? t_sum'(-win.sums[k]) : win.sums[k];
            n_big[k] = |mag[SUM_W-1:THR_W];
            n_sq[k]  = SQ_W'(mag[THR_W-1:0]) * SQ_W'(mag[THR_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_sq[k] <= n_sq[k];
            end
            r_lin_big <= |n_big[NVEC-1:0];
            r_ang_big <= |n_big[NCOMP-1:NVEC];
            r_lin_tsq <= SQ_W'(r_lin_thr) * SQ_W'(r_lin_thr);
            r_ang_tsq <= SQ_W'(r_ang_thr) * SQ_W'(r_ang_thr);
            r_full3   <= win.full;
        end
    end

    // Stage 4: squared lengths against squared thresholds
    assign lin_acc = ACC_W'(r_sq[0]) + ACC_W'(r_sq[1]) + ACC_W'(r_sq[2]);
    assign ang_acc = ACC_W'(r_sq[3]) + ACC_W'(r_sq[4]) + ACC_W'(r_sq[5]);
    assign n_at_rest = r_full3
                    && !r_lin_big && (lin_acc < ACC_W'(r_lin_tsq))
                    && !r_ang_big && (ang_acc < ACC_W'(r_ang_tsq));

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            r_at_rest <= n_at_rest;
            r_full_o  <= r_full3;
        end
    end

    assign o_out_valid   = r_vo;
    assign o_at_rest     = r_at_rest;
    assign o_window_full = r_full_o;

    // At rest is only reported with a full window
    a_rest_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_at_rest |-> o_window_full)
        else $error("at rest without full window");

    // A zero linear threshold never gives at rest
    a_zero_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && rdy4 && r_lin_tsq == '0 |=> !r_at_rest)
        else $error("at rest under zero threshold");

    // A taken result with nothing behind it empties the output stage
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !r_v3 |=> !o_out_valid)
        else $error("result repeated");

endmodule

>>> verif/windowed_stillness_detector_tb.sv
// ----------------------------------------------------------------------------
// windowed_stillness_detector_tb
// Self-checking bench for the stillness detector. A scoreboard keeps its own
// sample ring, running sums and thresholds, forecasts the flags of every
// accepted item and compares them with each result in order. Stimulus is a
// short directed run followed by bursts of quiet, noisy and mixed velocity
// samples under a series of threshold settings, with random stalls on both
// channels and long output hold-offs.
// ----------------------------------------------------------------------------
module windowed_stillness_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 206;
    localparam int NUM_SETTINGS = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_GAP      = 40;
    localparam int MAX_SHOWN    = 30;
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {BURST_QUIET, BURST_NOISY, BURST_MIXED} burst_kind_e;

    typedef struct packed {
        logic at_rest;
        logic window_full;
    } rest_flags_t;

    // ------------------------------------------------------------------------
    // Scoreboard: window forecast plus in-order flag check
    // ------------------------------------------------------------------------
    class stillness_board;
        longint           ring [WINDOW][NCOMP];
        longint           sums [NCOMP];
        int               pos;
        bit               wrapped;
        logic [THR_W-1:0] lin_thr;
        logic [THR_W-1:0] ang_thr;
        rest_flags_t      flags_due [$];
        int               errors;
        int               results;
        int               rest_count;
        int               full_count;

        function new();
            foreach (ring[w, k]) ring[w][k] = 0;
            foreach (sums[k]) sums[k] = 0;
            pos        = 0;
            wrapped    = 1'b0;
            lin_thr    = THR_RESET;
            ang_thr    = THR_RESET;
            errors     = 0;
            results    = 0;
            rest_count = 0;
            full_count = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
            if (idx == CFG_LIN_THR)
                lin_thr = val;
            else if (idx == CFG_ANG_THR)
                ang_thr = val;
        endfunction

        // Exact squared length of one summed vector against thr squared
        function bit below_limit(int base, logic [THR_W-1:0] thr);
            logic [127:0] acc;
            logic [127:0] mag;
            logic [127:0] lim;
            acc = '0;
            for (int k = 0; k < NVEC; k++) begin
                mag = (sums[base+k] < 0) ? 128'(-sums[base+k]) : 128'(sums[base+k]);
                acc = acc + mag * mag;
            end
            lim = 128'(thr) * 128'(thr);
            return acc < lim;
        endfunction

        // Advance the window by one accepted item and queue its flags
        function void note_sample(t_vec v);
            rest_flags_t f;
            longint      x;
            pos = pos + 1;
            if (pos > WINDOW - 1) begin
                pos     = 0;
                wrapped = 1'b1;
            end
            for (int k = 0; k < NCOMP; k++) begin
                x             = longint'(signed'(v[k]));
                sums[k]       = sums[k] + x - ring[pos][k];
                ring[pos][k]  = x;
            end
            f.window_full = wrapped;
            f.at_rest     = wrapped && below_limit(0, lin_thr) && below_limit(NVEC, ang_thr);
            flags_due.push_back(f);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("[%0t] mismatch on result %0d: %s", $time, results, what);
        endtask

        task check_flags(logic rest, logic full);
            rest_flags_t f;
            results++;
            if (flags_due.size() == 0) begin
                report_mismatch("result with no item outstanding");
                return;
            end
            f = flags_due.pop_front();
            if (rest !== f.at_rest)
                report_mismatch($sformatf("at_rest %b, want %b", rest, f.at_rest));
            if (full !== f.window_full)
                report_mismatch($sformatf("window_full %b, want %b", full, f.window_full));
            if (f.at_rest)
                rest_count++;
            if (f.window_full)
                full_count++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] lin_x     = '0;
    logic signed [DATA_W-1:0] lin_y     = '0;
    logic signed [DATA_W-1:0] lin_z     = '0;
    logic signed [DATA_W-1:0] ang_x     = '0;
    logic signed [DATA_W-1:0] ang_y     = '0;
    logic signed [DATA_W-1:0] ang_z     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     at_rest;
    logic                     window_full;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx   = CFG_LIN_THR;
    logic [THR_W-1:0]         cfg_data  = '0;

    stillness_board board;
    int             items_sent    = 0;
    int             src_idle_pct  = 31;
    int             sink_idle_pct = 75;
    int             hold_requests = 0;
    int             hold_served   = 0;
    int             cycle_count   = 0;

    windowed_stillness_detector dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_lin_x       (lin_x),
        .i_lin_y       (lin_y),
        .i_lin_z       (lin_z),
        .i_ang_x       (ang_x),
        .i_ang_y       (ang_y),
        .i_ang_z       (ang_z),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_at_rest     (at_rest),
        .o_window_full (window_full),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles: %0d of %0d results seen",
                     cycle_count, board.results, items_sent);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitor: note accepted items, then check accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_sample({ang_z, ang_y, ang_x, lin_z, lin_y, lin_x});
            if (out_valid && out_ready)
                board.check_flags(at_rest, window_full);
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_sample(input t_vec v);
        int gap;
        // idle profile: receiver-heavy, then sender-heavy, then none
        if (items_sent < 560) begin
            src_idle_pct  = 31;
            sink_idle_pct = 75;
        end else if (items_sent < 1120) begin
            src_idle_pct  = 75;
            sink_idle_pct = 31;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99, 0) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        lin_x    <= v[0];
        lin_y    <= v[1];
        lin_z    <= v[2];
        ang_x    <= v[3];
        ang_y    <= v[4];
        ang_z    <= v[5];
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Stop offering and wait until every item has its result
    task automatic drain();
        in_valid <= 1'b0;
        while (board.results < items_sent)
            @(posedge clk);
    endtask

    // Leaves the write enable high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.set_threshold(idx, val);
    endtask

    task automatic program_thresholds(input logic [THR_W-1:0] lin, input logic [THR_W-1:0] ang);
        write_reg(CFG_LIN_THR, lin);
        write_reg(CFG_ANG_THR, ang);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sample generation
    // ------------------------------------------------------------------------
    // Small zero-mean component scaled to the threshold
    function automatic t_comp quiet_comp(logic [THR_W-1:0] thr, int shift);
        logic [31:0] span;
        span = 32'(thr >> shift) + 32'd1;
        return t_comp'($urandom_range(2 * span, 0) - span);
    endfunction

    function automatic t_comp noisy_comp();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_vec make_sample(burst_kind_e kind, int shift);
        t_vec v;
        bit   lin_loud;
        bit   ang_loud;
        lin_loud = (kind == BURST_NOISY) || (kind == BURST_MIXED && $urandom_range(9, 0) == 0);
        ang_loud = (kind == BURST_NOISY) || (kind == BURST_MIXED && $urandom_range(9, 0) == 0);
        for (int k = 0; k < NVEC; k++) begin
            v[k]        = lin_loud ? noisy_comp() : quiet_comp(board.lin_thr, shift);
            v[k + NVEC] = ang_loud ? noisy_comp() : quiet_comp(board.ang_thr, shift);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_vec             v;
        burst_kind_e      kind;
        logic [THR_W-1:0] lin_set;
        logic [THR_W-1:0] ang_set;
        int               shift_base;
        int               burst_len;
        int               n;
        int               pick;

        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes first, so they leave the window right after the wrap
        v = '0;
        send_sample({NCOMP{32'h7FFF_FFFF}});
        send_sample({NCOMP{32'h8000_0000}});
        // zeros up to the first wrap; the last one completes the window
        repeat (8) send_sample(v);
        // evict the positive extreme: sums at full negative scale
        send_sample(v);
        send_sample(v);
        // linear sum exactly on the threshold, then one under it
        v[0] = 32'sd105;
        send_sample(v);
        v[0] = -32'sd1;
        send_sample(v);
        // same pair on the angular side
        v = '0;
        v[5] = -32'sd105;
        send_sample(v);
        v[5] = 32'sd1;
        send_sample(v);

        // writes to indexes outside the register list change nothing
        drain();
        write_reg(CFG_SPARE_A, '0);
        write_reg(CFG_SPARE_B, THR_MAX);
        cfg_we <= 1'b0;
        v = '0;
        repeat (3) send_sample(v);

        // Random bursts under a series of threshold settings
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: begin lin_set = THR_MAX;  ang_set = THR_MAX;  end
                1: begin lin_set = '0;       ang_set = THR_MAX;  end
                2: begin lin_set = THR_MAX;  ang_set = '0;       end
                3: begin lin_set = 31'd1;    ang_set = 31'd1;    end
                4: begin
                    lin_set = THR_W'($urandom_range(4096, 16));
                    ang_set = THR_W'($urandom_range(4096, 16));
                end
                5: begin
                    lin_set = THR_W'($urandom());
                    ang_set = THR_W'($urandom());
                end
                6: begin lin_set = THR_RESET; ang_set = THR_RESET; end
                default: begin
                    lin_set = THR_W'($urandom_range(1 << 20, 1));
                    ang_set = THR_W'($urandom_range(1 << 20, 1));
                end
            endcase
            drain();
            program_thresholds(lin_set, ang_set);
            // long output hold-off while items keep coming
            if (p == 1 || p == 6)
                hold_requests++;
            shift_base = $urandom_range(3, 1);
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(99, 0);
                kind = (pick < 70) ? BURST_QUIET : (pick < 85) ? BURST_NOISY : BURST_MIXED;
                burst_len = $urandom_range(40, 8);
                for (int j = 0; j < burst_len && n < PHASE_ITEMS; j++) begin
                    send_sample(make_sample(kind, shift_base + $urandom_range(1, 0)));
                    n++;
                    // one pause mid-stream until the block has emptied
                    if (p == 3 && n == 100)
                        drain();
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d samples over %0d threshold settings, zero to full scale",
                 items_sent, NUM_SETTINGS + 1);
        $display("results: %0d with window full, %0d at rest, %0d mismatches",
                 board.full_count, board.rest_count, board.errors);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
